// File: rtl/core/mbe_pkg.sv
// Shared types, constants and saturating helpers for the multibrot escape-time block.
package mbe_pkg;

    localparam int FRAC_BITS = 56;
    localparam int MAX_POWER = 8;
    localparam int ITER_BITS = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [63:0] FX_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] FX_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FRAC_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POWER       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAILOUT_SQ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_RE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_IM    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_EN    = 3'd6;

    typedef struct packed {
        logic signed [63:0] pixel_re;
        logic signed [63:0] pixel_im;
    } in_t;

    typedef struct packed {
        logic [15:0]        step_count;
        logic               escaped;
        logic               overflowed;
        logic signed [63:0] final_re;
        logic signed [63:0] final_im;
        logic signed [63:0] deriv_re;
        logic signed [63:0] deriv_im;
    } out_t;

    typedef struct packed {
        logic [3:0]         power;
        logic [15:0]        max_iter;
        logic [62:0]        bailout_sq;
        logic               pixel_mode;
        logic signed [63:0] fixed_re;
        logic signed [63:0] fixed_im;
        logic               derivative_enable;
    } cfg_t;

    typedef struct packed {
        logic               go;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [127:0]       prod;
        logic signed [63:0] fx;
        logic               ovf;
    } mul_rsp_t;

    typedef struct packed {
        logic               ovf;
        logic signed [63:0] val;
    } sat_t;

    function automatic sat_t fx_add(input logic signed [63:0] a, input logic signed [63:0] b);
        sat_t r;
        logic signed [63:0] s;
        s = a + b;
        r.val = s;
        r.ovf = 1'b0;
        if (a[63] == b[63] && s[63] != a[63]) begin
            r.ovf = 1'b1;
            r.val = a[63] ? FX_MIN : FX_MAX;
        end
        return r;
    endfunction

    function automatic sat_t fx_sub(input logic signed [63:0] a, input logic signed [63:0] b);
        sat_t r;
        logic signed [63:0] s;
        s = a - b;
        r.val = s;
        r.ovf = 1'b0;
        if (a[63] != b[63] && s[63] != a[63]) begin
            r.ovf = 1'b1;
            r.val = a[63] ? FX_MIN : FX_MAX;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/mbe_mul.sv
// Multi-cycle 64x64 fixed-point multiplier built on one 32x32 multiplier.
module mbe_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  mbe_pkg::mul_req_t req,
    output mbe_pkg::mul_rsp_t rsp
);
    import mbe_pkg::*;

    logic [63:0]        ma_reg, ma_next;
    logic [63:0]        mb_reg, mb_next;
    logic               neg_reg, neg_next;
    logic [127:0]       acc_reg, acc_next;
    logic [2:0]         idx_reg, idx_next;
    logic               act_reg, act_next;
    logic               done_reg, done_next;
    logic signed [63:0] fx_reg, fx_next;
    logic               ovf_reg, ovf_next;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [63:0]  q, lim;
    logic         big;

    // Select partial operands and weight
    always_comb
    begin
        pa = idx_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb = idx_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp = 64'(pa) * 64'(pb);
        case ({idx_reg[1], idx_reg[0]})
            2'b00:   pp_sh = {64'd0, pp};
            2'b11:   pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // Scale, saturate and sign the product
    always_comb
    begin
        q   = acc_reg[FRAC_BITS+63:FRAC_BITS];
        lim = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        big = (|acc_reg[127:FRAC_BITS+64]) || (q > lim);
        if (big)
        begin
            q = lim;
        end
    end

    always_comb
    begin
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        act_next  = act_reg;
        done_next = 1'b0;
        fx_next   = fx_reg;
        ovf_next  = ovf_reg;
        if (req.go)
        begin
            ma_next  = req.a[63] ? 64'd0 - req.a : req.a;
            mb_next  = req.b[63] ? 64'd0 - req.b : req.b;
            neg_next = req.a[63] != req.b[63];
            acc_next = '0;
            idx_next = '0;
            act_next = 1'b1;
        end
        else if (act_reg)
        begin
            if (idx_reg[2])
            begin
                // finish: present scaled result
                fx_next   = neg_reg ? 64'd0 - q : q;
                ovf_next  = big;
                done_next = 1'b1;
                act_next  = 1'b0;
            end
            else
            begin
                acc_next = acc_reg + pp_sh;
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            act_reg  <= act_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        fx_reg  <= fx_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
    assign rsp.fx   = fx_reg;
    assign rsp.ovf  = ovf_reg;

endmodule

// File: rtl/core/mbe_core.sv
// Sequencer that runs the escape-time iteration on the shared multiplier.
module mbe_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  mbe_pkg::in_t      pixel,
    input  mbe_pkg::cfg_t     cfg,
    output logic              busy,
    output logic              fin,
    output mbe_pkg::out_t     res,
    output mbe_pkg::mul_req_t mreq,
    input  mbe_pkg::mul_rsp_t mrsp
);
    import mbe_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SQ_GO    = 9'b000000010,
        S_SQ_WAIT  = 9'b000000100,
        S_EVAL     = 9'b000001000,
        S_MUL_GO   = 9'b000010000,
        S_MUL_WAIT = 9'b000100000,
        S_COMB     = 9'b001000000,
        S_DADD     = 9'b010000000,
        S_DFIN     = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        PH_POW = 2'd0,
        PH_Z   = 2'd1,
        PH_D   = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;
    logic [1:0]  k_reg, k_next;
    logic [3:0]  e_reg, e_next;
    logic [ITER_BITS-1:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next;
    logic fin_reg, fin_next;
    logic esc_reg, esc_next;
    logic signed [63:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [63:0] cr_reg, cr_next, ci_reg, ci_next;
    logic signed [63:0] dr_reg, dr_next, di_reg, di_next;
    logic signed [63:0] pr_reg, pr_next, pi_reg, pi_next;
    logic signed [63:0] nr_reg, nr_next, ni_reg, ni_next;
    logic signed [63:0] prod_reg [4];
    logic signed [63:0] prod_next [4];
    logic [127:0] sq_reg, sq_next;

    logic [3:0] pw;
    logic [ITER_BITS-1:0] lim;
    logic outside;
    sat_t cre, cim, zre, zim, are, aim, dre;
    logic signed [63:0] yr, yi;

    // Clamp power and step limit
    always_comb
    begin
        if (cfg.power < 4'd2)
            pw = 4'd2;
        else if (cfg.power > 4'(MAX_POWER))
            pw = 4'(MAX_POWER);
        else
            pw = cfg.power;
        lim = cfg.max_iter[ITER_BITS-1:0];
        if (lim == '0)
            lim = ITER_BITS'(1);
    end

    assign outside = (|sq_reg[127:FRAC_BITS+64])
                  || (sq_reg[FRAC_BITS+63:FRAC_BITS] > {1'b0, cfg.bailout_sq});

    // Complex product combine, constant add, derivative add
    always_comb
    begin
        cre = fx_sub(prod_reg[0], prod_reg[1]);
        cim = fx_add(prod_reg[2], prod_reg[3]);
        zre = fx_add(cre.val, cr_reg);
        zim = fx_add(cim.val, ci_reg);
        are = fx_add(dr_reg, pr_reg);
        aim = fx_add(di_reg, pi_reg);
        dre = fx_add(dr_reg, FX_ONE);
    end

    // Multiplier operand selection
    always_comb
    begin
        yr = (ph_reg == PH_D) ? dr_reg : zr_reg;
        yi = (ph_reg == PH_D) ? di_reg : zi_reg;
        mreq.go = (state_reg == S_MUL_GO) || (state_reg == S_SQ_GO);
        mreq.a  = pr_reg;
        mreq.b  = yr;
        if (state_reg == S_SQ_GO)
        begin
            mreq.a = k_reg[0] ? zi_reg : zr_reg;
            mreq.b = k_reg[0] ? zi_reg : zr_reg;
        end
        else
        begin
            case (k_reg)
                2'd0:    begin mreq.a = pr_reg; mreq.b = yr; end
                2'd1:    begin mreq.a = pi_reg; mreq.b = yi; end
                2'd2:    begin mreq.a = pr_reg; mreq.b = yi; end
                default: begin mreq.a = pi_reg; mreq.b = yr; end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next  = ph_reg;
        k_next   = k_reg;
        e_next   = e_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        esc_next = esc_reg;
        fin_next = 1'b0;
        zr_next = zr_reg; zi_next = zi_reg;
        cr_next = cr_reg; ci_next = ci_reg;
        dr_next = dr_reg; di_next = di_reg;
        pr_next = pr_reg; pi_next = pi_reg;
        nr_next = nr_reg; ni_next = ni_reg;
        sq_next = sq_reg;
        for (int i = 0; i < 4; i++)
            prod_next[i] = prod_reg[i];

        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    // load operands by mode
                    if (cfg.pixel_mode)
                    begin
                        zr_next = pixel.pixel_re; zi_next = pixel.pixel_im;
                        cr_next = cfg.fixed_re;   ci_next = cfg.fixed_im;
                        dr_next = FX_ONE;
                    end
                    else
                    begin
                        cr_next = pixel.pixel_re; ci_next = pixel.pixel_im;
                        zr_next = cfg.fixed_re;   zi_next = cfg.fixed_im;
                        dr_next = '0;
                    end
                    di_next  = '0;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    esc_next = 1'b0;
                    k_next   = '0;
                    state_next = S_SQ_GO;
                end
            end
            S_SQ_GO:
                state_next = S_SQ_WAIT;
            S_SQ_WAIT:
            begin
                if (mrsp.done)
                begin
                    if (k_reg[0])
                    begin
                        sq_next = sq_reg + mrsp.prod;
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        sq_next = mrsp.prod;
                        k_next  = 2'd1;
                        state_next = S_SQ_GO;
                    end
                end
            end
            S_EVAL:
            begin
                if (ovf_reg || outside)
                begin
                    esc_next = 1'b1;
                    fin_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg != '0 && cnt_reg >= lim)
                begin
                    fin_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // begin a step
                    ovf_next = 1'b0;
                    pr_next = zr_reg; pi_next = zi_reg;
                    e_next  = 4'd2;
                    ph_next = (pw > 4'd2) ? PH_POW : PH_Z;
                    k_next  = '0;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
                state_next = S_MUL_WAIT;
            S_MUL_WAIT:
            begin
                if (mrsp.done)
                begin
                    prod_next[k_reg] = mrsp.fx;
                    if (ph_reg != PH_D)
                        ovf_next = ovf_reg | mrsp.ovf;
                    k_next = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? S_COMB : S_MUL_GO;
                end
            end
            S_COMB:
            begin
                k_next = '0;
                case (ph_reg)
                    PH_POW:
                    begin
                        pr_next = cre.val; pi_next = cim.val;
                        ovf_next = ovf_reg | cre.ovf | cim.ovf;
                        e_next = e_reg + 4'd1;
                        if (e_reg + 4'd1 >= pw)
                            ph_next = PH_Z;
                        state_next = S_MUL_GO;
                    end
                    PH_Z:
                    begin
                        nr_next = zre.val; ni_next = zim.val;
                        ovf_next = ovf_reg | cre.ovf | cim.ovf | zre.ovf | zim.ovf;
                        if (cfg.derivative_enable)
                        begin
                            ph_next = PH_D;
                            state_next = S_MUL_GO;
                        end
                        else
                        begin
                            // commit the step
                            zr_next = zre.val; zi_next = zim.val;
                            cnt_next = cnt_reg + ITER_BITS'(1);
                            state_next = S_SQ_GO;
                        end
                    end
                    default:
                    begin
                        // hold the term in the power registers, sum from zero
                        pr_next = cre.val; pi_next = cim.val;
                        dr_next = '0; di_next = '0;
                        e_next  = '0;
                        state_next = S_DADD;
                    end
                endcase
            end
            S_DADD:
            begin
                dr_next = are.val; di_next = aim.val;
                e_next  = e_reg + 4'd1;
                if (e_reg + 4'd1 >= pw)
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                if (!cfg.pixel_mode)
                    dr_next = dre.val;
                zr_next = nr_reg; zi_next = ni_reg;
                cnt_next = cnt_reg + ITER_BITS'(1);
                k_next = '0;
                state_next = S_SQ_GO;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg  <= ph_next;
        k_reg   <= k_next;
        e_reg   <= e_next;
        cnt_reg <= cnt_next;
        ovf_reg <= ovf_next;
        esc_reg <= esc_next;
        zr_reg <= zr_next; zi_reg <= zi_next;
        cr_reg <= cr_next; ci_reg <= ci_next;
        dr_reg <= dr_next; di_reg <= di_next;
        pr_reg <= pr_next; pi_reg <= pi_next;
        nr_reg <= nr_next; ni_reg <= ni_next;
        sq_reg <= sq_next;
        for (int i = 0; i < 4; i++)
            prod_reg[i] <= prod_next[i];
    end

    assign busy = (state_reg != S_IDLE) || fin_reg;
    assign fin  = fin_reg;
    assign res.step_count = 16'(cnt_reg);
    assign res.escaped    = esc_reg;
    assign res.overflowed = ovf_reg;
    assign res.final_re   = zr_reg;
    assign res.final_im   = zi_reg;
    assign res.deriv_re   = dr_reg;
    assign res.deriv_im   = di_reg;

endmodule

// File: rtl/core/multibrot_escape_time_top.sv
// Top level of the multibrot escape-time block: config registers, core and result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   input    | start, busy          | pixel (pixel_re, pixel_im)
//   result   | done (one-cycle)     | result
//   config   | cfg_we               | cfg_index, cfg_data
//
// Each 64x64 product is issued and then waits while the shared 32x32 multiplier sums its
// four partial products. A step takes power-1 complex products, plus one more and power
// additions with derivative tracking; done shows once the item escapes or max_iter steps run.
// Reset clears the configuration to its defaults and the sequencer to idle.
// busy stays high from acceptance until the cycle done is shown; done cannot stall.
module multibrot_escape_time_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mbe_pkg::in_t                   pixel,
    output logic                           done,
    output mbe_pkg::out_t                  result,
    input  logic                           cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [63:0]                    cfg_data
);
    import mbe_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    out_t     res_reg;
    logic     done_reg;
    logic     core_busy, core_fin, go;
    out_t     core_res;
    mul_req_t mreq;
    mul_rsp_t mrsp;

    assign go = start && !core_busy;

    // Apply configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_POWER:      cfg_next.power             = cfg_data[3:0];
                REG_MAX_ITER:   cfg_next.max_iter          = cfg_data[15:0];
                REG_BAILOUT_SQ: cfg_next.bailout_sq        = cfg_data[62:0];
                REG_PIXEL_MODE: cfg_next.pixel_mode        = cfg_data[0];
                REG_FIXED_RE:   cfg_next.fixed_re          = cfg_data;
                REG_FIXED_IM:   cfg_next.fixed_im          = cfg_data;
                REG_DERIV_EN:   cfg_next.derivative_enable = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power             <= 4'd2;
            cfg_reg.max_iter          <= 16'd256;
            cfg_reg.bailout_sq        <= 63'h0400_0000_0000_0000;
            cfg_reg.pixel_mode        <= 1'b0;
            cfg_reg.fixed_re          <= '0;
            cfg_reg.fixed_im          <= '0;
            cfg_reg.derivative_enable <= 1'b0;
            done_reg                  <= 1'b0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            done_reg <= core_fin;
        end
    end

    // Capture the finished item
    always_ff @(posedge clk)
    begin
        if (core_fin)
            res_reg <= core_res;
    end

    mbe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    mbe_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .pixel (pixel),
        .cfg   (cfg_reg),
        .busy  (core_busy),
        .fin   (core_fin),
        .res   (core_res),
        .mreq  (mreq),
        .mrsp  (mrsp)
    );

    assign busy   = core_busy;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the multibrot escape-time block.
`timescale 1ns / 1ps

module testbench;
    import mbe_pkg::*;

    typedef struct packed {
        logic signed [63:0] re;
        logic signed [63:0] im;
    } cplx_t;

    typedef struct {
        in_t  pix;
        bit   known;
        out_t want;
    } row_t;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t pixel = '0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_POWER;
    logic [63:0] cfg_data = '0;
    logic busy;
    logic done;
    out_t result;

    // Mirror of the configuration registers
    logic [3:0]         m_power = 4'd2;
    logic [15:0]        m_max_iter = 16'd256;
    logic [62:0]        m_bailout = 63'd288230376151711744;
    logic               m_mode = 1'b0;
    logic signed [63:0] m_fixed_re = '0;
    logic signed [63:0] m_fixed_im = '0;
    logic               m_deriv_en = 1'b0;

    out_t pending_results[$];
    row_t dir_rows[$];
    bit   sat_hit;
    int   bad = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   escapes_seen = 0;
    int   overflows_seen = 0;

    multibrot_escape_time_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .pixel(pixel),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #1_000_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Saturating fixed point arithmetic; sat_hit records any clamp
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            sat_hit = 1'b1;
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    function automatic logic signed [63:0] sat_diff(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
        begin
            sat_hit = 1'b1;
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    function automatic logic [127:0] magnitude(input logic signed [63:0] a);
        logic [63:0] m;
        m = a[63] ? -a : a;
        return {64'd0, m};
    endfunction

    function automatic logic signed [63:0] sat_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [127:0] pr;
        logic [63:0]  q;
        logic [63:0]  lim;
        logic         neg;
        neg = a[63] ^ b[63];
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        pr = magnitude(a) * magnitude(b);
        q = pr[119:56];
        if (pr[127:120] != 0 || q > lim)
        begin
            sat_hit = 1'b1;
            q = lim;
        end
        return neg ? -q : q;
    endfunction

    function automatic cplx_t cplx_mul(input cplx_t a, input cplx_t b);
        cplx_t r;
        r.re = sat_diff(sat_mul(a.re, b.re), sat_mul(a.im, b.im));
        r.im = sat_add(sat_mul(a.re, b.im), sat_mul(a.im, b.re));
        return r;
    endfunction

    function automatic bit beyond_bailout(input cplx_t z);
        logic [128:0] s;
        s = {1'b0, magnitude(z.re) * magnitude(z.re)} + {1'b0, magnitude(z.im) * magnitude(z.im)};
        if (s[128:120] != 0)
            return 1'b1;
        return s[119:56] > {1'b0, m_bailout};
    endfunction

    // Iterate one pixel against the mirrored configuration
    function automatic out_t escape_result(input in_t pix);
        out_t  r;
        cplx_t z, c, d, pm1, nz, t, nd;
        int    pw, lim, cnt, e;
        bit    esc, ovf;
        pw = m_power;
        if (pw < 2) pw = 2;
        if (pw > MAX_POWER) pw = MAX_POWER;
        lim = m_max_iter;
        if (lim == 0) lim = 1;
        cnt = 0;
        esc = 1'b0;
        ovf = 1'b0;
        if (m_mode)
        begin
            z = '{pix.pixel_re, pix.pixel_im};
            c = '{m_fixed_re, m_fixed_im};
            d = '{ONE, 64'sd0};
        end
        else
        begin
            c = '{pix.pixel_re, pix.pixel_im};
            z = '{m_fixed_re, m_fixed_im};
            d = '{64'sd0, 64'sd0};
        end
        if (beyond_bailout(z))
            esc = 1'b1;
        else
        begin
            forever
            begin
                sat_hit = 1'b0;
                pm1 = z;
                for (e = 2; e < pw; e++)
                    pm1 = cplx_mul(pm1, z);
                nz = cplx_mul(pm1, z);
                nz.re = sat_add(nz.re, c.re);
                nz.im = sat_add(nz.im, c.im);
                ovf = sat_hit;
                // derivative clamps are silent
                if (m_deriv_en)
                begin
                    t = cplx_mul(pm1, d);
                    nd = '0;
                    for (e = 0; e < pw; e++)
                    begin
                        nd.re = sat_add(nd.re, t.re);
                        nd.im = sat_add(nd.im, t.im);
                    end
                    if (!m_mode)
                        nd.re = sat_add(nd.re, ONE);
                    d = nd;
                end
                z = nz;
                cnt++;
                if (ovf || beyond_bailout(z))
                begin
                    esc = 1'b1;
                    break;
                end
                if (cnt >= lim)
                    break;
            end
        end
        r.step_count = cnt[15:0];
        r.escaped = esc;
        r.overflowed = ovf;
        r.final_re = z.re;
        r.final_im = z.im;
        r.deriv_re = d.re;
        r.deriv_im = d.im;
        return r;
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (result.escaped) escapes_seen++;
            if (result.overflowed) overflows_seen++;
            if (pending_results.size() == 0)
            begin
                bad++;
                if (bad <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                out_t want;
                want = pending_results.pop_front();
                if (result.step_count !== want.step_count || result.escaped !== want.escaped ||
                    result.overflowed !== want.overflowed || result.final_re !== want.final_re ||
                    result.final_im !== want.final_im || result.deriv_re !== want.deriv_re ||
                    result.deriv_im !== want.deriv_im)
                begin
                    bad++;
                    if (bad <= 10)
                    begin
                        $display("mismatch at result %0d", results_seen);
                        $display("  expected cnt=%0d esc=%b ovf=%b z=%h,%h d=%h,%h",
                                 want.step_count, want.escaped, want.overflowed,
                                 want.final_re, want.final_im, want.deriv_re, want.deriv_im);
                        $display("  actual   cnt=%0d esc=%b ovf=%b z=%h,%h d=%h,%h",
                                 result.step_count, result.escaped, result.overflowed,
                                 result.final_re, result.final_im, result.deriv_re,
                                 result.deriv_im);
                    end
                end
            end
        end
    end

    // Present one item and hold it until accepted; start stays high
    task automatic issue(input in_t p, input bit known, input out_t want);
        pixel <= p;
        start <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_results.push_back(known ? want : escape_result(p));
        items_sent++;
    endtask

    // Drop start for a random burst now and then
    task automatic pace(input bit quiet);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Hold until every result is in, then let the block settle
    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write one register; the caller drops the enable after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_POWER:      m_power = val[3:0];
            REG_MAX_ITER:   m_max_iter = val[15:0];
            REG_BAILOUT_SQ: m_bailout = val[62:0];
            REG_PIXEL_MODE: m_mode = val[0];
            REG_FIXED_RE:   m_fixed_re = val;
            REG_FIXED_IM:   m_fixed_im = val;
            REG_DERIV_EN:   m_deriv_en = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] pw, input logic [63:0] mit,
                             input logic [63:0] bail, input logic [63:0] mode,
                             input logic [63:0] fre, input logic [63:0] fim,
                             input logic [63:0] den);
        write_reg(REG_POWER, pw);
        write_reg(REG_MAX_ITER, mit);
        write_reg(REG_BAILOUT_SQ, bail);
        write_reg(REG_PIXEL_MODE, mode);
        write_reg(REG_FIXED_RE, fre);
        write_reg(REG_FIXED_IM, fim);
        write_reg(REG_DERIV_EN, den);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [63:0] rand_coord();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            7, 8: return r;
            9:
            begin
                case ($urandom_range(0, 4))
                    0: return {1'b0, {63{1'b1}}};
                    1: return {1'b1, 63'd0};
                    2: return ONE;
                    3: return -ONE;
                    default: return 64'sd0;
                endcase
            end
            default: return {{5{r[58]}}, r[58:0]};
        endcase
    endfunction

    task automatic random_items(input int count, input bit quiet, input bit no_zero);
        in_t p;
        out_t none;
        none = '0;
        for (int i = 0; i < count; i++)
        begin
            p.pixel_re = rand_coord();
            p.pixel_im = rand_coord();
            if (no_zero && p.pixel_re == 0 && p.pixel_im == 0)
                p.pixel_im = 64'sd1;
            issue(p, 1'b0, none);
            pace(quiet);
            if (i % 97 == 96)
            begin
                start <= 1'b0;
                drain();
            end
        end
        start <= 1'b0;
        drain();
    endtask

    function automatic row_t row(input logic signed [63:0] re, input logic signed [63:0] im,
                                 input bit known, input out_t want);
        row_t r;
        r.pix = '{re, im};
        r.known = known;
        r.want = want;
        return r;
    endfunction

    function automatic out_t res(input int cnt, input bit esc, input logic signed [63:0] zr,
                                 input logic signed [63:0] zi, input logic signed [63:0] dr);
        out_t r;
        r.step_count = cnt[15:0];
        r.escaped = esc;
        r.overflowed = 1'b0;
        r.final_re = zr;
        r.final_im = zi;
        r.deriv_re = dr;
        r.deriv_im = 64'sd0;
        return r;
    endfunction

    initial
    begin
        logic signed [63:0] mx, mn;
        out_t none;
        int split;
        mx = {1'b0, {63{1'b1}}};
        mn = {1'b1, 63'd0};
        none = '0;

        // Reset settings: c mode from z0 = 0, power 2, 256 steps, radius 2
        dir_rows.push_back(row(mx, mx, 1, res(1, 1, mx, mx, 0)));
        dir_rows.push_back(row(mn, mn, 1, res(1, 1, mn, mn, 0)));
        dir_rows.push_back(row(mx, mn, 1, res(1, 1, mx, mn, 0)));
        dir_rows.push_back(row(mn, 0, 1, res(1, 1, mn, 0, 0)));
        dir_rows.push_back(row(0, 0, 1, res(256, 0, 0, 0, 0)));
        dir_rows.push_back(row(-2 * ONE, 0, 0, none));
        dir_rows.push_back(row(ONE / 4, 0, 0, none));
        dir_rows.push_back(row(-(ONE / 4) * 3, ONE / 10, 0, none));
        dir_rows.push_back(row(ONE, ONE, 0, none));
        dir_rows.push_back(row(0, ONE, 0, none));
        split = dir_rows.size();
        // z0 mode, power 8, zero step limit, extreme fixed c, derivative on
        dir_rows.push_back(row(3 * ONE, 0, 1, res(0, 1, 3 * ONE, 0, ONE)));
        dir_rows.push_back(row(mn, mn, 1, res(0, 1, mn, mn, ONE)));
        dir_rows.push_back(row(mx, 0, 1, res(0, 1, mx, 0, ONE)));
        dir_rows.push_back(row(0, 0, 0, none));
        dir_rows.push_back(row(ONE, 0, 0, none));
        dir_rows.push_back(row(ONE / 2, -(ONE / 2), 0, none));
        dir_rows.push_back(row(-ONE, 0, 0, none));
        dir_rows.push_back(row(0, ONE, 0, none));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            if (i == split)
            begin
                start <= 1'b0;
                drain();
                configure(8, 0, 64'd288230376151711744, 1, mx, mn, 1);
            end
            issue(dir_rows[i].pix, dir_rows[i].known, dir_rows[i].want);
            pace(1'b0);
        end
        start <= 1'b0;
        drain();

        // Random phases over a spread of settings
        configure(2, 24, 64'd288230376151711744, 0, 0, 0, 1);
        random_items(150, 0, 0);
        configure(3, 16, 64'd288230376151711744, 1, -(ONE / 5) * 4, ONE / 6, 1);
        random_items(150, 0, 0);
        configure(8, 8, 64'd288230376151711744, 0, 0, 0, 1);
        random_items(120, 0, 0);
        configure(15, 6, 64'h7FFF_FFFF_FFFF_FFFF, 1, ONE / 3, -(ONE / 2), 0);
        random_items(120, 0, 0);
        configure(0, 65535, 0, 0, 0, 0, 0);
        random_items(150, 0, 1);
        configure(5, 0, 64'd4611686018427387904, 1, rand_coord(), rand_coord(), 1);
        random_items(150, 0, 0);
        configure(4, 20, ONE, 0, ONE / 10, ONE / 10, 0);
        random_items(150, 1, 0);

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("sent %0d pixels over 9 settings (power 0..15, limits 0..65535, both modes)",
                 items_sent);
        $display("checked %0d results: %0d escaped, %0d saturated, %0d mismatches",
                 results_seen, escapes_seen, overflows_seen, bad);
        if (bad == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
